// ===== rtl/qjt_pkg.sv =====
// ----------------------------------------------------------------------------
// qjt_pkg
// Shared types, codes and saturation helpers for the quintic trajectory block.
// ----------------------------------------------------------------------------
package qjt_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_ABORT = 2'd2;

  localparam logic [2:0] STAT_IDLE   = 3'd0;
  localparam logic [2:0] STAT_RUN    = 3'd1;
  localparam logic [2:0] STAT_DONE   = 3'd2;
  localparam logic [2:0] STAT_ACCEPT = 3'd3;
  localparam logic [2:0] STAT_REJECT = 3'd4;

  localparam logic [2:0] REG_START_Q1 = 3'd0;
  localparam logic [2:0] REG_START_Q2 = 3'd1;
  localparam logic [2:0] REG_START_Q3 = 3'd2;
  localparam logic [2:0] REG_GOAL_Q1  = 3'd3;
  localparam logic [2:0] REG_GOAL_Q2  = 3'd4;
  localparam logic [2:0] REG_GOAL_Q3  = 3'd5;
  localparam logic [2:0] REG_DURATION = 3'd6;

  localparam logic [25:0] ELAPSED_MAX = 26'h3FF_FFFF;
  localparam logic [63:0] VEL_GAIN    = 64'd30000000;
  localparam logic [63:0] ACC_GAIN    = 64'd60000000;
  localparam logic [63:0] USEC_PER_S  = 64'd1000000;
  localparam logic [63:0] ACC_LIMIT   = 64'd9000000000000;
  localparam logic [63:0] ACC_SAT_MAG = 64'h1_0000_0000;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_DONE = 2'd2
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TAU, S_T2, S_T3, S_S, S_W, S_Q, S_P,
    S_PM, S_VQ, S_VM, S_VD, S_AP, S_AM, S_AD, S_AM2, S_AD2, S_OUT
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -64'sh8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] signed_sat(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = 32'h8000_0000;
      else r = 32'(-mag[31:0]);
    end else begin
      if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/qjt_if.sv =====
// ----------------------------------------------------------------------------
// qjt_in_if / qjt_out_if
// Valid-ready channels for command items and trajectory result items.
// ----------------------------------------------------------------------------
interface qjt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] step_us;
  modport source (output valid, func, step_us, input ready);
  modport sink (input valid, func, step_us, output ready);
endinterface

interface qjt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] pos_q1;
  logic [31:0] pos_q2;
  logic [31:0] pos_q3;
  logic [31:0] vel_q1;
  logic [31:0] vel_q2;
  logic [31:0] vel_q3;
  logic [31:0] acc_q1;
  logic [31:0] acc_q2;
  logic [31:0] acc_q3;
  modport source (output valid, status, pos_q1, pos_q2, pos_q3, vel_q1, vel_q2, vel_q3,
                  acc_q1, acc_q2, acc_q3, input ready);
  modport sink (input valid, status, pos_q1, pos_q2, pos_q3, vel_q1, vel_q2, vel_q3,
                acc_q1, acc_q2, acc_q3, output ready);
endinterface

// ===== rtl/quintic_joint_trajectory_top.sv =====
// Start, abort and idle items offer their result in the cycle after acceptance.
// A running tick runs one 64-step tau divide (skipped once elapsed reaches the duration),
// six bit-serial multiplies, then per joint up to six multiplies and three 64-step divides.
// Multiplies run one multiplier bit a cycle; one item is worked on at a time, and the
// next item is accepted in the cycle after the result item is taken.
// Reset (synchronous, rst_n low) clears config and latched registers, elapsed time and mode to idle.
// ----------------------------------------------------------------------------
// quintic_joint_trajectory_top
// Three-joint quintic trajectory generator on a shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
module quintic_joint_trajectory_top
  import qjt_pkg::*;
#(
  parameter int DT_MAX_US     = 50000,
  parameter int T_MIN_US      = 2000,
  parameter int TAU_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  qjt_in_if.sink      in_ch,
  qjt_out_if.source   out_ch
);

  localparam int TW = TAU_FRAC_BITS + 3;
  localparam logic [63:0] ONE  = 64'd1 << TAU_FRAC_BITS;
  localparam logic [63:0] HALF = ONE >> 1;

  state_t state_r, state_nxt;
  mode_t  mode_r;

  logic [31:0] cfg_start_r [3];
  logic [31:0] cfg_goal_r [3];
  logic [25:0] cfg_dur_r;
  logic [31:0] lat_start_r [3];
  logic [31:0] lat_goal_r [3];
  logic [25:0] dur_r;
  logic [25:0] elapsed_r;

  logic [TW-1:0] tau_r, t2_r, t3_r, s_r, w_r, q_r, p_r;
  logic          pneg_r;
  logic [63:0]   tmp_r;
  logic [1:0]    jidx_r;

  logic [63:0] opa_r, opb_r, prod_r;
  logic [25:0] rem_r;
  logic [6:0]  cnt_r;
  logic        busy_r;

  logic [2:0]  status_r;
  logic [31:0] pos_r [3];
  logic [31:0] vel_r [3];
  logic [31:0] acc_r [3];

  logic        in_acc, is_div, unit_done, op_state, skip_tau;
  logic [63:0] ld_a, ld_b, fm_res, poly, half_dur, tau64, h_val;
  logic [26:0] rem_sh;
  logic        rem_ge, h_neg;
  logic signed [32:0] d_s;
  logic        dn;
  logic [32:0] ad;
  logic [15:0] step_c;
  logic [26:0] e_sum;
  logic        dur_bad;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign tau64  = 64'(tau_r);
  assign fm_res = (prod_r + HALF) >> TAU_FRAC_BITS;
  assign poly   = 64'd10 * ONE + (64'(t2_r) << 2) + (64'(t2_r) << 1)
                  - ((tau64 << 4) - tau64);
  assign h_neg  = (tau64 << 1) > ONE;
  assign h_val  = h_neg ? (tau64 << 1) - ONE : ONE - (tau64 << 1);
  assign half_dur = 64'(dur_r >> 1);
  assign rem_sh = {rem_r, opa_r[63]};
  assign rem_ge = rem_sh >= {1'b0, dur_r};
  assign d_s    = $signed({lat_goal_r[jidx_r][31], lat_goal_r[jidx_r]})
                  - $signed({lat_start_r[jidx_r][31], lat_start_r[jidx_r]});
  assign dn     = d_s[32];
  assign ad     = dn ? 33'(-d_s) : 33'(d_s);
  assign step_c = (in_ch.step_us > 16'(DT_MAX_US)) ? 16'(DT_MAX_US) : in_ch.step_us;
  assign e_sum  = {1'b0, elapsed_r} + 27'(step_c);
  assign dur_bad = ({6'd0, cfg_dur_r} < 32'(T_MIN_US)) || (cfg_dur_r == 26'd0);
  assign skip_tau = elapsed_r >= dur_r;
  assign unit_done = busy_r && (is_div ? (cnt_r == 7'd0) : (opb_r == 64'd0));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_TICK && mode_r != MODE_IDLE) state_nxt = S_TAU;
          else state_nxt = S_OUT;
        end
      end
      S_TAU: if ((!busy_r && skip_tau) || unit_done) state_nxt = S_T2;
      S_T2:  if (unit_done) state_nxt = S_T3;
      S_T3:  if (unit_done) state_nxt = S_S;
      S_S:   if (unit_done) state_nxt = S_W;
      S_W:   if (unit_done) state_nxt = S_Q;
      S_Q:   if (unit_done) state_nxt = S_P;
      S_P:   if (unit_done) state_nxt = S_PM;
      S_PM:  if (unit_done) state_nxt = S_VQ;
      S_VQ:  if (unit_done) state_nxt = S_VM;
      S_VM:  if (unit_done) state_nxt = S_VD;
      S_VD:  if (unit_done) state_nxt = S_AP;
      S_AP:  if (unit_done) state_nxt = S_AM;
      S_AM:  if (unit_done) state_nxt = S_AD;
      S_AD: begin
        if (unit_done) begin
          if (prod_r > ACC_LIMIT) state_nxt = (jidx_r == 2'd2) ? S_OUT : S_PM;
          else state_nxt = S_AM2;
        end
      end
      S_AM2: if (unit_done) state_nxt = S_AD2;
      S_AD2: if (unit_done) state_nxt = (jidx_r == 2'd2) ? S_OUT : S_PM;
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ld_a     = 64'd0;
    ld_b     = 64'd0;
    is_div   = 1'b0;
    op_state = 1'b1;
    unique case (state_r)
      S_TAU: begin ld_a = 64'(elapsed_r) << TAU_FRAC_BITS; is_div = 1'b1; end
      S_T2:  begin ld_a = tau64;        ld_b = tau64; end
      S_T3:  begin ld_a = 64'(t2_r);    ld_b = tau64; end
      S_S:   begin ld_a = poly;         ld_b = 64'(t3_r); end
      S_W:   begin ld_a = tau64;        ld_b = ONE - tau64; end
      S_Q:   begin ld_a = 64'(w_r);     ld_b = 64'(w_r); end
      S_P:   begin ld_a = 64'(w_r);     ld_b = h_val; end
      S_PM:  begin ld_a = 64'(ad);      ld_b = 64'(s_r); end
      S_VQ:  begin ld_a = 64'(ad);      ld_b = 64'(q_r); end
      S_VM:  begin ld_a = tmp_r;        ld_b = VEL_GAIN; end
      S_VD:  begin ld_a = tmp_r;        is_div = 1'b1; end
      S_AP:  begin ld_a = 64'(ad);      ld_b = 64'(p_r); end
      S_AM:  begin ld_a = tmp_r;        ld_b = ACC_GAIN; end
      S_AD:  begin ld_a = tmp_r;        is_div = 1'b1; end
      S_AM2: begin ld_a = tmp_r;        ld_b = USEC_PER_S; end
      S_AD2: begin ld_a = tmp_r;        is_div = 1'b1; end
      default: op_state = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= MODE_IDLE;
      elapsed_r <= 26'd0;
      busy_r    <= 1'b0;
      jidx_r    <= 2'd0;
      cfg_dur_r <= 26'd0;
      dur_r     <= 26'd0;
      for (int k = 0; k < 3; k++) begin
        cfg_start_r[k] <= 32'd0;
        cfg_goal_r[k]  <= 32'd0;
        lat_start_r[k] <= 32'd0;
        lat_goal_r[k]  <= 32'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_START_Q1: cfg_start_r[0] <= cfg_wdata;
          REG_START_Q2: cfg_start_r[1] <= cfg_wdata;
          REG_START_Q3: cfg_start_r[2] <= cfg_wdata;
          REG_GOAL_Q1:  cfg_goal_r[0]  <= cfg_wdata;
          REG_GOAL_Q2:  cfg_goal_r[1]  <= cfg_wdata;
          REG_GOAL_Q3:  cfg_goal_r[2]  <= cfg_wdata;
          REG_DURATION: cfg_dur_r      <= cfg_wdata[25:0];
          default: ;
        endcase
      end

      if (op_state && !busy_r && !(state_r == S_TAU && skip_tau)) begin
        opa_r  <= ld_a;
        opb_r  <= ld_b;
        prod_r <= 64'd0;
        rem_r  <= 26'd0;
        cnt_r  <= 7'd64;
        busy_r <= 1'b1;
      end else if (busy_r && !unit_done) begin
        opa_r <= opa_r << 1;
        if (is_div) begin
          rem_r  <= rem_ge ? 26'(rem_sh - {1'b0, dur_r}) : rem_sh[25:0];
          prod_r <= {prod_r[62:0], rem_ge};
          cnt_r  <= cnt_r - 7'd1;
        end else begin
          if (opb_r[0]) prod_r <= prod_r + opa_r;
          opb_r <= opb_r >> 1;
        end
      end else if (unit_done) begin
        busy_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            jidx_r <= 2'd0;
            for (int k = 0; k < 3; k++) begin
              pos_r[k] <= 32'd0;
              vel_r[k] <= 32'd0;
              acc_r[k] <= 32'd0;
            end
            unique case (in_ch.func)
              FUNC_START: begin
                if (dur_bad) begin
                  mode_r   <= MODE_IDLE;
                  status_r <= STAT_REJECT;
                end else begin
                  for (int k = 0; k < 3; k++) begin
                    lat_start_r[k] <= cfg_start_r[k];
                    lat_goal_r[k]  <= cfg_goal_r[k];
                  end
                  dur_r     <= cfg_dur_r;
                  elapsed_r <= 26'd0;
                  mode_r    <= MODE_RUN;
                  status_r  <= STAT_ACCEPT;
                end
              end
              FUNC_ABORT: begin
                mode_r    <= MODE_IDLE;
                elapsed_r <= 26'd0;
                status_r  <= STAT_IDLE;
              end
              FUNC_TICK: begin
                status_r <= STAT_IDLE;
                if (mode_r != MODE_IDLE)
                  elapsed_r <= e_sum[26] ? ELAPSED_MAX : e_sum[25:0];
              end
              default: status_r <= {1'b0, mode_r};
            endcase
          end
        end
        S_TAU: begin
          if (!busy_r && skip_tau) begin
            tau_r  <= TW'(ONE);
            mode_r <= MODE_DONE;
          end else if (unit_done) begin
            tau_r <= prod_r[TW-1:0];
          end
        end
        S_T2: if (unit_done) t2_r <= fm_res[TW-1:0];
        S_T3: if (unit_done) t3_r <= fm_res[TW-1:0];
        S_S:  if (unit_done) s_r  <= fm_res[TW-1:0];
        S_W:  if (unit_done) w_r  <= fm_res[TW-1:0];
        S_Q:  if (unit_done) q_r  <= fm_res[TW-1:0];
        S_P: begin
          if (unit_done) begin
            p_r    <= fm_res[TW-1:0];
            pneg_r <= h_neg;
          end
        end
        S_PM: begin
          if (unit_done) begin
            pos_r[jidx_r] <= sat32(dn
              ? 64'(signed'(lat_start_r[jidx_r])) - signed'(fm_res)
              : 64'(signed'(lat_start_r[jidx_r])) + signed'(fm_res));
          end
        end
        S_VQ:  if (unit_done) tmp_r <= fm_res;
        S_VM:  if (unit_done) tmp_r <= prod_r + half_dur;
        S_VD:  if (unit_done) vel_r[jidx_r] <= signed_sat(dn, prod_r);
        S_AP:  if (unit_done) tmp_r <= fm_res;
        S_AM:  if (unit_done) tmp_r <= prod_r + half_dur;
        S_AD: begin
          if (unit_done) begin
            if (prod_r > ACC_LIMIT) begin
              acc_r[jidx_r] <= signed_sat(dn != pneg_r, ACC_SAT_MAG);
              jidx_r <= (jidx_r == 2'd2) ? 2'd0 : jidx_r + 2'd1;
              if (jidx_r == 2'd2) status_r <= {1'b0, mode_r};
            end else begin
              tmp_r <= prod_r;
            end
          end
        end
        S_AM2: if (unit_done) tmp_r <= prod_r + half_dur;
        S_AD2: begin
          if (unit_done) begin
            acc_r[jidx_r] <= signed_sat(dn != pneg_r, prod_r);
            jidx_r <= (jidx_r == 2'd2) ? 2'd0 : jidx_r + 2'd1;
            if (jidx_r == 2'd2) status_r <= {1'b0, mode_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = (state_r == S_OUT);
  assign out_ch.status = status_r;
  assign out_ch.pos_q1 = pos_r[0];
  assign out_ch.pos_q2 = pos_r[1];
  assign out_ch.pos_q3 = pos_r[2];
  assign out_ch.vel_q1 = vel_r[0];
  assign out_ch.vel_q2 = vel_r[1];
  assign out_ch.vel_q3 = vel_r[2];
  assign out_ch.acc_q1 = acc_r[0];
  assign out_ch.acc_q2 = acc_r[1];
  assign out_ch.acc_q3 = acc_r[2];

`ifndef ASSERT_OFF
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("second item taken before result delivered");

  a_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
    jidx_r != 2'd3)
    else $error("joint index out of range");

  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STAT_RUN) |-> (mode_r == MODE_RUN))
    else $error("running status reported while not running");
`endif

endmodule
